// ===== sv/kwm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package kwm_pkg;

   // field widths fixed by the transaction format
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned LANE_FW = 3;
   localparam int unsigned CFG_W   = 4;

   // command codes of an input transaction
   typedef enum logic [1:0] {
      CMD_ELEMENT = 2'd0,
      CMD_FINAL   = 2'd1,
      CMD_CLOSE   = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type                     command;
      logic [LANE_FW-1:0]          lane;
      logic signed [VALUE_W-1:0]   element_value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]   merged_value;
      logic [LANE_FW-1:0]          source_lane;
      logic                        last;
      logic                        no_data;
   } rsp_type;

   // running result of one pass over the lane heads
   typedef struct packed {
      logic                        any;
      logic                        all_closed;
      logic                        ready;
      logic                        two_full;
      logic [LANE_FW-1:0]          best_lane;
      logic signed [VALUE_W-1:0]   best_value;
   } scan_type;

   localparam scan_type SCAN_INIT = '{
      any:        1'b0,
      all_closed: 1'b1,
      ready:      1'b1,
      two_full:   1'b0,
      best_lane:  '0,
      best_value: '0
   };

endpackage
`default_nettype wire

// ===== sv/kwm_scan_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
module kwm_scan_step
   import kwm_pkg::*;
(
   input  scan_type                  scan_cur,
   input  logic [LANE_FW-1:0]        lane_idx,
   input  logic signed [VALUE_W-1:0] lane_value,
   input  logic                      lane_full,
   input  logic                      lane_closed,
   output scan_type                  scan_nxt
);

   logic is_less;

   // shared signed comparator; strict less keeps the lower lane on a tie
   assign is_less = lane_value < scan_cur.best_value;

   // fold one lane into the running minimum and the status flags
   always_comb begin
      scan_nxt = scan_cur;
      scan_nxt.all_closed = scan_cur.all_closed & lane_closed;
      if (lane_full) begin
         scan_nxt.any = 1'b1;
         if (scan_cur.any) begin
            scan_nxt.two_full = 1'b1;
         end
         if (!scan_cur.any || is_less) begin
            scan_nxt.best_lane  = lane_idx;
            scan_nxt.best_value = lane_value;
         end
      end else if (!lane_closed) begin
         scan_nxt.ready = 1'b0;
      end
   end

endmodule
`default_nettype wire

// ===== sv/kwm_heads.sv =====
`timescale 1ns / 1ps
`default_nettype none
module kwm_heads
   import kwm_pkg::*;
#(
   parameter int unsigned HEADS  = 8,
   parameter int unsigned LANE_W = 3
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  req_type                   wr,
   input  logic [CFG_W-1:0]          n_lanes,
   input  logic                      pop_en,
   input  logic [LANE_W-1:0]         pop_idx,
   input  logic                      clear_en,
   input  logic [LANE_W-1:0]         rd_idx,
   output logic signed [VALUE_W-1:0] rd_value,
   output logic                      rd_full,
   output logic                      rd_closed
);

   logic signed [VALUE_W-1:0] head_value_ff [HEADS];
   logic [HEADS-1:0]          head_full_ff;
   logic [HEADS-1:0]          head_full_in;
   logic [HEADS-1:0]          lane_closed_ff;
   logic [HEADS-1:0]          lane_closed_in;
   logic                      lane_ok;
   logic [LANE_W-1:0]         wr_idx;
   logic                      take_value;

   // a transaction counts only for an open lane taking part
   assign wr_idx  = wr.lane[LANE_W-1:0];
   assign lane_ok = wr_en && ({1'b0, wr.lane} < n_lanes) && !lane_closed_ff[wr_idx]
                    && (wr.command != CMD_NONE);
   assign take_value = lane_ok && (wr.command != CMD_CLOSE) && !head_full_ff[wr_idx];

   // head value store, only meaningful where the full flag is set
   always_ff @(posedge clock) begin
      if (take_value) begin
         head_value_ff[wr_idx] <= wr.element_value;
      end
   end

   // full and closed flags
   always_comb begin
      head_full_in   = head_full_ff;
      lane_closed_in = lane_closed_ff;
      if (clear_en) begin
         head_full_in   = '0;
         lane_closed_in = '0;
      end else begin
         if (take_value) begin
            head_full_in[wr_idx] = 1'b1;
         end
         if (lane_ok && (wr.command != CMD_ELEMENT)) begin
            lane_closed_in[wr_idx] = 1'b1;
         end
         if (pop_en) begin
            head_full_in[pop_idx] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_full_ff   <= '0;
         lane_closed_ff <= '0;
      end else begin
         head_full_ff   <= head_full_in;
         lane_closed_ff <= lane_closed_in;
      end
   end

   // scan read port
   assign rd_value  = head_value_ff[rd_idx];
   assign rd_full   = head_full_ff[rd_idx];
   assign rd_closed = lane_closed_ff[rd_idx];

endmodule
`default_nettype wire

// ===== sv/k_way_sorted_merge_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Merges up to eight ascending streams of signed 32-bit values into one ascending
// stream. Each input transaction gives an element to a lane or closes it; lane heads
// are kept in registers and one comparator walks them one lane per cycle. With n lanes
// in use (csr lanes_in_use, clamped to 1..min(LANES,8)) a selection pass that emits
// scans the n lanes, makes a decision and loads the output register; the closing pass
// that finds nothing to emit scans the lanes and decides. An input transaction keeps
// the input not ready until its closing pass is done, or until its last result ends
// the merge (an end marker counts as a result), and while the output register waits
// on rsp_ready. Ties go to the lowest lane. The final result of a merge has last set;
// a merge that ends without emitting anything on that transaction gives one result
// with no_data and last set and zero value fields. The block then clears itself for
// the next merge. lanes_in_use may only be written while the block is idle.
module k_way_sorted_merge_top
   import kwm_pkg::*;
#(
   parameter int unsigned LANES = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data
);

   localparam int unsigned HEADS  = (LANES < 8) ? LANES : 8;
   localparam int unsigned LANE_W = $clog2(HEADS);
   localparam logic [CFG_W-1:0] HEADS_N = CFG_W'(HEADS);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DECIDE = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [CFG_W-1:0]    lanes_in_use_ff;
   logic [CFG_W-1:0]    n_lanes;
   logic [LANE_W-1:0]   n_last;
   logic [LANE_W-1:0]   scan_idx_ff, scan_idx_in;
   scan_type            scan_ff, scan_in, scan_step;
   logic                emitted_ff, emitted_in;
   logic                marker_ff, marker_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic                req_fire;
   logic                out_free;
   logic                pop_en;
   logic                clear_en;
   logic signed [VALUE_W-1:0] rd_value;
   logic                rd_full;
   logic                rd_closed;

   // lane count register and its clamp
   always_ff @(posedge clock) begin
      if (reset) begin
         lanes_in_use_ff <= CFG_W'(8);
      end else if (csr_wr_en) begin
         lanes_in_use_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (lanes_in_use_ff == '0) begin
         n_lanes = CFG_W'(1);
      end else if (lanes_in_use_ff > HEADS_N) begin
         n_lanes = HEADS_N;
      end else begin
         n_lanes = lanes_in_use_ff;
      end
   end

   assign n_last = LANE_W'(n_lanes - CFG_W'(1));

   // handshakes
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // lane head store
   kwm_heads #(
      .HEADS  (HEADS),
      .LANE_W (LANE_W)
   ) u_heads (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (req_fire),
      .wr        (req_data),
      .n_lanes   (n_lanes),
      .pop_en    (pop_en),
      .pop_idx   (scan_ff.best_lane[LANE_W-1:0]),
      .clear_en  (clear_en),
      .rd_idx    (scan_idx_ff),
      .rd_value  (rd_value),
      .rd_full   (rd_full),
      .rd_closed (rd_closed)
   );

   // shared compare unit
   kwm_scan_step u_step (
      .scan_cur    (scan_ff),
      .lane_idx    (LANE_FW'(scan_idx_ff)),
      .lane_value  (rd_value),
      .lane_full   (rd_full),
      .lane_closed (rd_closed),
      .scan_nxt    (scan_step)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      scan_idx_in  = scan_idx_ff;
      scan_in      = scan_ff;
      emitted_in   = emitted_ff;
      marker_in    = marker_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      pop_en       = 1'b0;
      clear_en     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in    = ST_SCAN;
               scan_idx_in = '0;
               scan_in     = SCAN_INIT;
               emitted_in  = 1'b0;
            end
         end
         ST_SCAN: begin
            scan_in     = scan_step;
            scan_idx_in = scan_idx_ff + LANE_W'(1);
            if (scan_idx_ff == n_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (scan_ff.ready && scan_ff.any) begin
               state_in  = ST_EMIT;
               marker_in = 1'b0;
            end else if (!emitted_ff && !scan_ff.any && scan_ff.all_closed) begin
               state_in  = ST_EMIT;
               marker_in = 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (marker_ff) begin
                  rsp_data_in = '{merged_value: '0, source_lane: '0,
                                  last: 1'b1, no_data: 1'b1};
                  clear_en    = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  rsp_data_in = '{merged_value: scan_ff.best_value,
                                  source_lane:  scan_ff.best_lane,
                                  last:         scan_ff.all_closed && !scan_ff.two_full,
                                  no_data:      1'b0};
                  if (scan_ff.all_closed && !scan_ff.two_full) begin
                     clear_en = 1'b1;
                     state_in = ST_IDLE;
                  end else begin
                     pop_en      = 1'b1;
                     emitted_in  = 1'b1;
                     scan_idx_in = '0;
                     scan_in     = SCAN_INIT;
                     state_in    = ST_SCAN;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         emitted_ff   <= 1'b0;
         marker_ff    <= 1'b0;
         scan_idx_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         emitted_ff   <= emitted_in;
         marker_ff    <= marker_in;
         scan_idx_ff  <= scan_idx_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== sv/kwm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module kwm_checker
   import kwm_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input req_type          req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rsp_type          rsp_data
);

   // the block is busy in the cycle after taking a transaction
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input still ready right after a transaction");

   // a waiting input transaction holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("input changed while waiting");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // an empty marker always ends the merge
   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.no_data |-> rsp_data.last)
      else $error("no_data result without last");

   // an empty marker carries zero fields
   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.no_data |->
         (rsp_data.merged_value == '0) && (rsp_data.source_lane == '0))
      else $error("no_data result with non-zero fields");

endmodule

bind k_way_sorted_merge_top kwm_checker u_kwm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_data    (req_data),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_data    (rsp_data)
);
`default_nettype wire
